/* rtl/core/dh_forward_kinematics_chain_assert.svh */
// assertion macros shared by the checker
`ifndef DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH
`define DHFK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhfk assertion failed");
`define DHFK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhfk assertion failed");
`endif

/* rtl/core/dhfk_pkg.sv */
package dhfk_pkg;
  localparam int ANGLE_BITS       = 16;
  localparam int LENGTH_FRAC_BITS = 8;
  localparam int CORDIC_STAGES    = 16;
  localparam int CSTAGE_W         = 4;
  localparam logic signed [24:0] CORDIC_GAIN_INV = 25'sd2547003;
  localparam logic signed [15:0] ROT_ONE = 16'sd16384;
  localparam logic signed [23:0] POS_MAX = 24'sd8388607;
  localparam logic signed [23:0] POS_MIN = 24'sh80_0000;

  typedef struct packed {
    logic signed [15:0] joint_angle;
    logic signed [15:0] link_offset;
    logic signed [15:0] link_len;
    logic signed [15:0] link_twist;
    logic               first_joint;
  } dhfk_in_t;

  typedef struct packed {
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } dhfk_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORD_T, ST_CORD_A, ST_JOINT, ST_MAC, ST_DONE
  } dhfk_state_t;

  function automatic logic [31:0] atan_phase(input logic [CSTAGE_W-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0:  v = 32'd536870912;
      4'd1:  v = 32'd316933406;
      4'd2:  v = 32'd167458907;
      4'd3:  v = 32'd85004756;
      4'd4:  v = 32'd42667331;
      4'd5:  v = 32'd21354465;
      4'd6:  v = 32'd10680862;
      4'd7:  v = 32'd5340245;
      4'd8:  v = 32'd2670163;
      4'd9:  v = 32'd1335087;
      4'd10: v = 32'd667544;
      4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;
      4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;
      default: v = 32'd20861;
    endcase
    return v;
  endfunction

  // clamp to [-1, 1] in q1.14
  function automatic logic signed [15:0] clamp_rot(input logic signed [25:0] v);
    logic signed [15:0] r;
    if (v > 26'sd16384) r = ROT_ONE;
    else if (v < -26'sd16384) r = -ROT_ONE;
    else r = v[15:0];
    return r;
  endfunction
endpackage

/* rtl/core/dhfk_cordic.sv */
module dhfk_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);
  localparam logic [31:0] QMASK = ~((32'd1 << (32 - dhfk_pkg::ANGLE_BITS)) - 32'd1);

  logic signed [25:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [dhfk_pkg::CSTAGE_W-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;
  logic [31:0] ph, ph_f;
  logic fl;
  logic signed [25:0] dx, dy, xr, yr;
  logic signed [32:0] at;

  always_comb begin
    ph   = {angle, 16'd0} & QMASK;
    fl   = ph[31] ^ ph[30];
    ph_f = fl ? ph + 32'h8000_0000 : ph;
    dx   = y_r >>> i_r;
    dy   = x_r >>> i_r;
    at   = {1'b0, dhfk_pkg::atan_phase(i_r)};
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; flip_nxt = flip_r; done_nxt = 1'b0;
    if (start) begin
      x_nxt = 26'(dhfk_pkg::CORDIC_GAIN_INV);
      y_nxt = '0;
      z_nxt = {ph_f[31], ph_f};
      i_nxt = '0;
      flip_nxt = fl;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r < 0) begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == 4'(dhfk_pkg::CORDIC_STAGES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; flip_r <= flip_nxt;
  end

  always_comb begin
    xr = (x_r + 26'sd128) >>> 8;
    yr = (y_r + 26'sd128) >>> 8;
    if (flip_r) begin
      xr = -xr; yr = -yr;
    end
  end

  assign done  = done_r;
  assign cos_o = dhfk_pkg::clamp_rot(xr);
  assign sin_o = dhfk_pkg::clamp_rot(yr);
endmodule

/* rtl/core/dhfk_mac.sv */
module dhfk_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [23:0] op_a,
  input  logic signed [17:0] op_b,
  output logic signed [43:0] acc
);
  // one shared multiplier with a registered product before accumulation
  logic signed [41:0] prod_r;
  logic               pv_r;
  logic signed [43:0] acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (pv_r) acc_nxt = acc_r + 44'(prod_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    pv_r   <= en;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

/* rtl/core/dh_forward_kinematics_chain.sv */
// DH forward kinematics chain: each transfer on the input channel carries one
// joint's theta, d, a and alpha; the block forms that joint's transform and
// right-multiplies the running base-to-joint transform by it, restarting
// from identity when first_joint is set. One result per joint: the new
// cumulative 3x3 rotation (q1.14, clamped to +-1) and position (q15.8,
// saturating). From input transfer to output valid an item goes through
// two cordic runs (theta, then alpha), then 18 steps through one
// shared 24x18 multiplier with a registered product: 6 joint terms of one
// product and 12 matrix entries of three products. Each product is issued,
// then waited on, and each step ends with a rounding phase. in_ready is low
// while an item is in flight and while the result waits to be taken, so a
// new item is not taken until the previous result has been taken.
module dh_forward_kinematics_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhfk_pkg::dhfk_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dhfk_pkg::dhfk_out_t out_data
);
  dhfk_pkg::dhfk_state_t state_r, state_nxt;

  dhfk_pkg::dhfk_in_t item_r;
  logic signed [15:0] rot_r [9];
  logic signed [23:0] pos_r [3];
  logic signed [15:0] jr_r [9];
  logic signed [16:0] jp_r [3];  // a*cos and a*sin can reach +-2^15
  logic signed [15:0] ct_r, st_r;
  logic [5:0] step_r, step_nxt;
  logic [1:0] ph_r;      // 0 issue, 1 wait, 2 accumulate-done
  // new cumulative entries staged so old rotation stays intact during products
  logic signed [15:0] nr_r [9];
  logic signed [23:0] np_r [3];

  logic cord_start, cord_done;
  logic signed [15:0] c_cos, c_sin;
  logic signed [15:0] c_ang;

  logic mac_clr, mac_en;
  logic signed [23:0] op_a;
  logic signed [17:0] op_b;
  logic signed [43:0] acc;
  logic signed [43:0] rnd;
  logic signed [25:0] pos_sum;
  logic signed [25:0] rnd_n;

  // theta is taken straight off the input at the transfer, alpha from the held item
  assign c_ang = (state_r == dhfk_pkg::ST_IDLE) ? in_data.joint_angle
                                                : item_r.link_twist;

  dhfk_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (c_ang),
    .done  (cord_done),
    .cos_o (c_cos),
    .sin_o (c_sin)
  );

  dhfk_mac u_mac (
    .clk   (clk),
    .clr   (mac_clr),
    .en    (mac_en),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // step plan: steps 0..5 joint terms, 6..17 matrix entries (9 rot then 3 pos)
  // each step takes k products (1 for joint terms, 3 for rot, 3 for pos)
  logic [1:0] nprod;
  logic [1:0] kk_r;
  logic [3:0] ent;
  logic [1:0] er, ec;

  always_comb begin
    ent = 4'(step_r - 6'd6);
    er = 2'd0;
    ec = 2'd0;
    // row and column of the entry being formed
    case (ent)
      4'd0, 4'd1, 4'd2: er = 2'd0;
      4'd3, 4'd4, 4'd5: er = 2'd1;
      4'd6, 4'd7, 4'd8: er = 2'd2;
      4'd9:             er = 2'd0;
      4'd10:            er = 2'd1;
      4'd11:            er = 2'd2;
      default:          er = 2'd0;
    endcase
    case (ent)
      4'd1, 4'd4, 4'd7: ec = 2'd1;
      4'd2, 4'd5, 4'd8: ec = 2'd2;
      default:          ec = 2'd0;
    endcase
    nprod = (step_r < 6'd6) ? 2'd1 : 2'd3;
  end

  // operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      6'd0: begin op_a = 24'(st_r); op_b = 18'(c_cos); end
      6'd1: begin op_a = 24'(st_r); op_b = 18'(c_sin); end
      6'd2: begin op_a = 24'(ct_r); op_b = 18'(c_cos); end
      6'd3: begin op_a = 24'(ct_r); op_b = 18'(c_sin); end
      6'd4: begin op_a = 24'(item_r.link_len); op_b = 18'(ct_r); end
      6'd5: begin op_a = 24'(item_r.link_len); op_b = 18'(st_r); end
      default: begin
        if (ent < 4'd9) begin
          op_a = 24'(rot_r[4'(er) * 4'd3 + 4'(kk_r)]);
          op_b = 18'(jr_r[4'(kk_r) * 4'd3 + 4'(ec)]);
        end else begin
          op_a = 24'(rot_r[4'(er) * 4'd3 + 4'(kk_r)]);
          op_b = 18'(jp_r[kk_r]);
        end
      end
    endcase
  end

  assign rnd = (acc + 44'sd8192) >>> 14;
  assign pos_sum = 26'(pos_r[er]) + 26'(rnd);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dhfk_pkg::ST_IDLE:   if (in_valid) state_nxt = dhfk_pkg::ST_CORD_T;
      dhfk_pkg::ST_CORD_T: if (cord_done) state_nxt = dhfk_pkg::ST_CORD_A;
      dhfk_pkg::ST_CORD_A: if (cord_done) state_nxt = dhfk_pkg::ST_MAC;
      dhfk_pkg::ST_MAC:
        if (ph_r == 2'd2 && step_r == 6'd17) state_nxt = dhfk_pkg::ST_DONE;
      dhfk_pkg::ST_DONE:   if (out_ready) state_nxt = dhfk_pkg::ST_IDLE;
      default:             state_nxt = dhfk_pkg::ST_IDLE;
    endcase
  end

  // output/control logic
  always_comb begin
    in_ready   = (state_r == dhfk_pkg::ST_IDLE);
    out_valid  = (state_r == dhfk_pkg::ST_DONE);
    cord_start = (state_r == dhfk_pkg::ST_IDLE && in_valid) ||
                 (state_r == dhfk_pkg::ST_CORD_T && cord_done);
    mac_en  = (state_r == dhfk_pkg::ST_MAC) && (ph_r == 2'd0);
    // accumulator held clear outside the product steps
    mac_clr = (state_r != dhfk_pkg::ST_MAC) || (ph_r == 2'd2);
  end

  assign step_nxt = step_r + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhfk_pkg::ST_IDLE;
      for (int i = 0; i < 9; i++) rot_r[i] <= (i % 4 == 0) ? dhfk_pkg::ROT_ONE : 16'sd0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      step_r <= '0;
      ph_r <= '0;
      kk_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        dhfk_pkg::ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            if (in_data.first_joint) begin
              for (int i = 0; i < 9; i++)
                rot_r[i] <= (i % 4 == 0) ? dhfk_pkg::ROT_ONE : 16'sd0;
              for (int i = 0; i < 3; i++) pos_r[i] <= '0;
            end
          end
          step_r <= '0; ph_r <= '0; kk_r <= '0;
        end
        dhfk_pkg::ST_CORD_T: begin
          if (cord_done) begin
            ct_r <= c_cos;
            st_r <= c_sin;
          end
        end
        dhfk_pkg::ST_CORD_A: begin
          if (cord_done) begin
            // cordic holds cos/sin of alpha while the joint terms are formed
            jr_r[0] <= ct_r; jr_r[3] <= st_r; jr_r[6] <= '0;
            jr_r[7] <= c_sin; jr_r[8] <= c_cos;
            jp_r[2] <= 17'(item_r.link_offset);
          end
        end
        dhfk_pkg::ST_MAC: begin
          case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              if (kk_r == nprod - 2'd1) begin
                ph_r <= 2'd2;
                kk_r <= '0;
              end else begin
                ph_r <= 2'd0;
                kk_r <= kk_r + 2'd1;
              end
            end
            default: begin
              ph_r <= 2'd0;
              step_r <= step_nxt;
              case (step_r)
                6'd0: jr_r[1] <= -rnd[15:0];
                6'd1: jr_r[2] <= rnd[15:0];
                6'd2: jr_r[4] <= rnd[15:0];
                6'd3: jr_r[5] <= -rnd[15:0];
                6'd4: jp_r[0] <= rnd[16:0];
                6'd5: jp_r[1] <= rnd[16:0];
                default: ;
              endcase
            end
          endcase
        end
        dhfk_pkg::ST_DONE: begin
          // the chain moves on once the result transfer happens
          if (out_ready) begin
            for (int i = 0; i < 9; i++) rot_r[i] <= nr_r[i];
            for (int i = 0; i < 3; i++) pos_r[i] <= np_r[i];
          end
        end
        default: ;
      endcase
    end
  end

  assign rnd_n = 26'(rnd > 44'sd16384 ? 44'sd16384 : (rnd < -44'sd16384 ? -44'sd16384 : rnd));

  always_ff @(posedge clk) begin
    if (state_r == dhfk_pkg::ST_MAC && ph_r == 2'd2 && step_r >= 6'd6) begin
      if (ent < 4'd9) nr_r[ent] <= dhfk_pkg::clamp_rot(rnd_n);
      else if (pos_sum > 26'(dhfk_pkg::POS_MAX)) np_r[er] <= dhfk_pkg::POS_MAX;
      else if (pos_sum < 26'(dhfk_pkg::POS_MIN)) np_r[er] <= dhfk_pkg::POS_MIN;
      else np_r[er] <= pos_sum[23:0];
    end
  end

  // staged entries stay put while the result waits
  assign out_data = '{nr_r[0], nr_r[1], nr_r[2], nr_r[3], nr_r[4],
                      nr_r[5], nr_r[6], nr_r[7], nr_r[8],
                      np_r[0], np_r[1], np_r[2]};
endmodule

/* rtl/core/dhfk_checker.sv */
`include "dh_forward_kinematics_chain_assert.svh"
module dhfk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dhfk_pkg::dhfk_out_t out_data
);
  `DHFK_ASSERT_IMPL(a_one_side, clk, rst_n, out_valid, !in_ready)
  `DHFK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `DHFK_ASSERT_NEXT(a_no_quick, clk, rst_n, in_valid && in_ready, !out_valid)
endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
